@@ sv/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, constants and controller/datapath signal groups for the
// least-recently-used key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int CAP_W = 5;
    localparam int KEY_W = 32;
    localparam int VAL_W = 31;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic load;
        logic cmp_on;
        logic update;
    } t_ctl;

    typedef struct packed {
        logic hit;
    } t_stat;

endpackage

@@ sv/lkvc_ram.sv @@
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/lkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: accepts a request, walks the entry store one address per
// cycle through a registered read, stops on a hit or after the last
// entry, then issues a single update cycle.
// ----------------------------------------------------------------------------
module lkvc_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  lkvc_pkg::t_stat                          i_stat,
    output lkvc_pkg::t_ctl                           o_ctl,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_rd_idx,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_cmp_idx
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]    r_state,      n_state;
    logic [IW-1:0] r_idx,        n_idx;
    logic          r_issue_done, n_issue_done;
    logic          r_cmp_on,     n_cmp_on;
    logic [IW-1:0] r_cmp_idx,    n_cmp_idx;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_cmp_on     = r_cmp_on;
        n_cmp_idx    = r_cmp_idx;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state      = S_SCAN;
                    n_idx        = '0;
                    n_issue_done = 1'b0;
                    n_cmp_on     = 1'b0;
                end
            end
            S_SCAN: begin
                n_cmp_on  = !r_issue_done;
                n_cmp_idx = r_idx;
                if (!r_issue_done) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                if (r_cmp_on && (i_stat.hit || r_cmp_idx == LAST_IDX)) begin
                    n_state  = S_UPDATE;
                    n_cmp_on = 1'b0;
                end
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state  = S_IDLE;
                n_cmp_on = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_cmp_on     <= 1'b0;
            r_cmp_idx    <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_issue_done <= n_issue_done;
            r_cmp_on     <= n_cmp_on;
            r_cmp_idx    <= n_cmp_idx;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_ctl.load   = start && (r_state == S_IDLE);
    assign o_ctl.cmp_on = r_cmp_on;
    assign o_ctl.update = (r_state == S_UPDATE);
    assign o_rd_idx     = r_idx;
    assign o_cmp_idx    = r_cmp_idx;

endmodule

@@ sv/lkvc_dp.sv @@
// ----------------------------------------------------------------------------
// lkvc_dp
// Cache datapath: key/value RAM, per-entry valid and recency lanes, fill
// count, capacity register, key compare and result register.
// ----------------------------------------------------------------------------
module lkvc_dp #(
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  lkvc_pkg::t_ctl                           i_ctl,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_idx,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_cmp_idx,
    output lkvc_pkg::t_stat                          o_stat,
    input  logic                                     i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]               i_cfg_wdata,
    input  logic                                     i_cmd,
    input  logic signed [lkvc_pkg::KEY_W-1:0]        i_key,
    input  logic [lkvc_pkg::VAL_W-1:0]               i_data_in,
    output logic                                     o_valid,
    output logic                                     o_found,
    output logic [lkvc_pkg::VAL_W-1:0]               o_data_out
);

    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LW    = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;
    localparam int KEY_W = lkvc_pkg::KEY_W;
    localparam int VAL_W = lkvc_pkg::VAL_W;

    logic [lkvc_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]           r_fill;
    logic [DEPTH-1:0]           r_valid;
    logic [IW-1:0]              r_age [DEPTH];

    logic                       r_op;
    logic [KEY_W-1:0]           r_key;
    logic [VAL_W-1:0]           r_data;
    logic                       r_hit;
    logic [IW-1:0]              r_slot;
    logic [VAL_W-1:0]           r_hit_val;
    logic                       r_free_found;
    logic [IW-1:0]              r_free_slot;
    logic [IW-1:0]              r_vic_slot;

    logic                       r_out_valid;
    logic                       r_found;
    logic [VAL_W-1:0]           r_dout;

    logic [KEY_W+VAL_W-1:0]     ram_rdata;
    logic [KEY_W-1:0]           rd_key;
    logic [VAL_W-1:0]           rd_val;
    logic                       hit;
    logic [DEPTH-1:0]           vic_vec;
    logic [LW-1:0]              cap_ext;
    logic [LW-1:0]              live_cap;
    logic                       full;
    logic                       ins_free;
    logic                       do_promote;
    logic                       ram_we;
    logic [IW-1:0]              upd_slot;
    logic [IW-1:0]              rank;

    lkvc_ram #(
        .WIDTH (KEY_W + VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (upd_slot),
        .i_wdata ({r_key, r_data}),
        .i_raddr (i_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[KEY_W+VAL_W-1:VAL_W];
    assign rd_val = ram_rdata[VAL_W-1:0];

    assign hit        = i_ctl.cmp_on && r_valid[i_cmp_idx] && (rd_key == r_key);
    assign o_stat.hit = hit;

    // oldest valid entry carries rank fill_count - 1
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            vic_vec[i] = r_valid[i] && (CNT_W'(r_age[i]) == (r_fill - CNT_W'(1)));
        end
    end

    assign cap_ext  = LW'(r_cap);
    assign live_cap = (cap_ext == '0) ? LW'(1) :
                      (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
    assign full     = (LW'(r_fill) >= live_cap);

    assign ins_free   = (r_op == lkvc_pkg::OP_PUT) && !r_hit && !full;
    assign do_promote = i_ctl.update && (r_hit || (r_op == lkvc_pkg::OP_PUT));
    assign ram_we     = i_ctl.update && (r_op == lkvc_pkg::OP_PUT);
    assign upd_slot   = ((r_op == lkvc_pkg::OP_PUT) && !r_hit) ?
                        (full ? r_vic_slot : r_free_slot) : r_slot;

    always_comb begin
        rank = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rank = rank | (r_age[i] & {IW{IW'(i) == upd_slot}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_age[i] <= '0;
            end
        end else if (do_promote) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (IW'(i) == upd_slot) begin
                    r_age[i]   <= '0;
                    r_valid[i] <= 1'b1;
                end else if (r_valid[i] && (ins_free || r_age[i] < rank)) begin
                    r_age[i] <= r_age[i] + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= lkvc_pkg::CAP_RESET;
            r_fill       <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_ctl.update && ins_free) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (i_ctl.load) begin
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (hit) begin
                    r_hit <= 1'b1;
                end
                if (i_ctl.cmp_on && !r_valid[i_cmp_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            r_out_valid <= i_ctl.update && (r_op == lkvc_pkg::OP_GET);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op   <= i_cmd;
            r_key  <= $unsigned(i_key);
            r_data <= i_data_in;
        end
        if (hit) begin
            r_slot    <= i_cmp_idx;
            r_hit_val <= rd_val;
        end
        if (i_ctl.cmp_on && !r_valid[i_cmp_idx] && !r_free_found) begin
            r_free_slot <= i_cmp_idx;
        end
        if (i_ctl.cmp_on && vic_vec[i_cmp_idx]) begin
            r_vic_slot <= i_cmp_idx;
        end
        if (i_ctl.update) begin
            r_found <= r_hit;
            r_dout  <= r_hit ? r_hit_val : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_data_out = r_dout;

endmodule

@@ sv/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The entry store is
// a single-port-read RAM that is searched one entry per cycle, so a request
// keeps busy high longer when its key sits further into the store, and
// longest on a miss or an insert. A get returns its result with
// o_valid high for exactly one cycle, the first cycle in which busy is low
// again; it must be taken then, as there is no way to hold it. A put returns
// nothing. The capacity register may be written at any idle time and takes
// effect for the next request.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  i_key,
    input  logic [lkvc_pkg::VAL_W-1:0]         i_data_in,
    output logic                               o_valid,
    output logic                               o_found,
    output logic [lkvc_pkg::VAL_W-1:0]         o_data_out,
    input  logic                               i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]         i_cfg_wdata
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lkvc_pkg::t_ctl  ctl;
    lkvc_pkg::t_stat stat;
    logic [IW-1:0]   rd_idx;
    logic [IW-1:0]   cmp_idx;

    lkvc_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_stat    (stat),
        .o_ctl     (ctl),
        .o_rd_idx  (rd_idx),
        .o_cmp_idx (cmp_idx)
    );

    lkvc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_rd_idx    (rd_idx),
        .i_cmp_idx   (cmp_idx),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .i_data_in   (i_data_in),
        .o_valid     (o_valid),
        .o_found     (o_found),
        .o_data_out  (o_data_out)
    );

`ifndef SYNTHESIS
    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(ctl.update))
        else $error("result strobe without a preceding update cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_hit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.hit |-> (busy && !ctl.update && !ctl.load))
        else $error("key match outside the search");

    a_update_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.update |=> !busy)
        else $error("busy still high after update cycle");
`endif

endmodule

@@ sim/lru_key_value_cache_tb.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the least-recently-used key/value cache. A driver
// feeds get/put requests from a queue with random idle bursts, a monitor
// mirrors the store, its recency ranks and the capacity, and checks every
// lookup result in order. Capacity is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W      = lkvc_pkg::KEY_W;
    localparam int VAL_W      = lkvc_pkg::VAL_W;
    localparam int CAP_W      = lkvc_pkg::CAP_W;
    localparam int DEPTH      = 16;
    localparam int AGE_W      = $clog2(DEPTH);
    localparam int STALL_MAX  = 2000;
    localparam int N_PHASES   = 10;
    localparam int PHASE_REQS = 170;

    typedef struct {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] data;
    } t_cache_req;

    typedef struct {
        logic             found;
        logic [VAL_W-1:0] data;
    } t_lookup_res;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_cmd = lkvc_pkg::OP_GET;
    logic signed [KEY_W-1:0] i_key = '0;
    logic [VAL_W-1:0]        i_data_in = '0;
    logic                    o_valid;
    logic                    o_found;
    logic [VAL_W-1:0]        o_data_out;
    logic                    i_cfg_we = 1'b0;
    logic [CAP_W-1:0]        i_cfg_wdata = '0;

    t_cache_req  pending_reqs[$];
    t_lookup_res expected_lookups[$];

    logic             mirror_valid [DEPTH];
    logic [KEY_W-1:0] mirror_key   [DEPTH];
    logic [VAL_W-1:0] mirror_val   [DEPTH];
    logic [AGE_W-1:0] mirror_age   [DEPTH];
    logic [CAP_W-1:0] mirror_fill;
    logic [CAP_W-1:0] mirror_cap;

    logic             xfer_done = 1'b0;
    logic             gaps_on = 1'b1;
    int               gap_left = 0;
    int               fail_count = 0;
    int               stall_cycles = 0;
    logic [KEY_W-1:0] key_pool[$];

    lru_key_value_cache #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .i_data_in  (i_data_in),
        .o_valid    (o_valid),
        .o_found    (o_found),
        .o_data_out (o_data_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int effective_capacity();
        int c;
        c = int'(mirror_cap);
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic void make_most_recent(int slot);
        logic [AGE_W-1:0] rank;
        rank = mirror_age[slot];
        for (int i = 0; i < DEPTH; i++) begin
            if (mirror_valid[i] && i != slot && mirror_age[i] < rank) begin
                mirror_age[i] = mirror_age[i] + 1'b1;
            end
        end
        mirror_age[slot] = '0;
    endfunction

    function automatic t_lookup_res apply_request(t_cache_req r);
        t_lookup_res      res;
        int               slot;
        logic [AGE_W-1:0] oldest;
        res.found = 1'b0;
        res.data  = '0;
        slot = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (slot < 0 && mirror_valid[i] && mirror_key[i] == r.key) slot = i;
        end
        if (r.cmd == lkvc_pkg::OP_GET) begin
            if (slot >= 0) begin
                make_most_recent(slot);
                res.found = 1'b1;
                res.data  = mirror_val[slot];
            end
            return res;
        end
        if (slot >= 0) begin
            mirror_val[slot] = r.data;
            make_most_recent(slot);
        end else if (int'(mirror_fill) >= effective_capacity()) begin
            // replace the least recent entry
            oldest = '0;
            for (int i = 0; i < DEPTH; i++) begin
                if (mirror_valid[i] && (slot < 0 || mirror_age[i] > oldest)) begin
                    oldest = mirror_age[i];
                    slot = i;
                end
            end
            if (slot >= 0) begin
                mirror_key[slot] = r.key;
                mirror_val[slot] = r.data;
                make_most_recent(slot);
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (slot < 0 && !mirror_valid[i]) slot = i;
            end
            if (slot >= 0) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (mirror_valid[i]) mirror_age[i] = mirror_age[i] + 1'b1;
                end
                mirror_valid[slot] = 1'b1;
                mirror_key[slot]   = r.key;
                mirror_val[slot]   = r.data;
                mirror_age[slot]   = '0;
                mirror_fill        = mirror_fill + 1'b1;
            end
        end
        return res;
    endfunction

    // driver
    always @(negedge i_clk) begin : drive_reqs
        t_cache_req nx;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else if (!start || xfer_done) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (pending_reqs.size() != 0 && gaps_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 2);
                start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nx = pending_reqs.pop_front();
                start     <= 1'b1;
                i_cmd     <= nx.cmd;
                i_key     <= nx.key;
                i_data_in <= nx.data;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin : watch_results
        t_lookup_res got_exp;
        t_lookup_res pred;
        t_cache_req  req;
        if (!i_rst_n) begin
            xfer_done <= 1'b0;
        end else begin
            if (o_valid) begin
                if (expected_lookups.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected result: found=%0b data=%h", o_found, o_data_out);
                end else begin
                    got_exp = expected_lookups.pop_front();
                    if (o_found !== got_exp.found || o_data_out !== got_exp.data) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("mismatch: found exp %0b got %0b, data exp %h got %h",
                                     got_exp.found, o_found, got_exp.data, o_data_out);
                    end
                end
            end
            xfer_done <= start && !busy;
            if (start && !busy) begin
                req.cmd  = i_cmd;
                req.key  = i_key;
                req.data = i_data_in;
                pred = apply_request(req);
                if (req.cmd == lkvc_pkg::OP_GET) expected_lookups.push_back(pred);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_req(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] data);
        t_cache_req r;
        r.cmd  = cmd;
        r.key  = key;
        r.data = data;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || busy || expected_lookups.size() != 0);
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        mirror_cap = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_data();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return w[VAL_W-1:0];
        endcase
    endfunction

    task automatic fill_phase(int n_reqs);
        int pool_n;
        int sel;
        pool_n = effective_capacity() + $urandom_range(0, 4);
        key_pool.delete();
        for (int i = 0; i < pool_n; i++) key_pool.push_back(pick_key_value());
        for (int i = 0; i < n_reqs; i++) begin
            sel = $urandom_range(0, 19);
            if (sel < 9)
                push_req(lkvc_pkg::OP_PUT, key_pool[$urandom_range(0, pool_n - 1)],
                         pick_data());
            else if (sel < 18)
                push_req(lkvc_pkg::OP_GET, key_pool[$urandom_range(0, pool_n - 1)],
                         pick_data());
            else
                push_req(sel[0] ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, $urandom,
                         pick_data());
        end
    endtask

    initial begin : run_test
        logic [CAP_W-1:0] caps [N_PHASES];
        caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd16, 5'd31, 5'd2, 5'd12, 5'd7, 5'd16};
        for (int i = 0; i < DEPTH; i++) begin
            mirror_valid[i] = 1'b0;
            mirror_key[i]   = '0;
            mirror_val[i]   = '0;
            mirror_age[i]   = '0;
        end
        mirror_fill = '0;
        mirror_cap  = lkvc_pkg::CAP_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, update of a present key, get on empty store
        push_req(lkvc_pkg::OP_GET, 32'h0000_0000, 31'h7fff_ffff);
        push_req(lkvc_pkg::OP_PUT, 32'h8000_0000, 31'h7fff_ffff);
        push_req(lkvc_pkg::OP_PUT, 32'h7fff_ffff, 31'h0000_0000);
        push_req(lkvc_pkg::OP_PUT, 32'hffff_ffff, 31'h0000_0001);
        push_req(lkvc_pkg::OP_PUT, 32'h0000_0000, 31'h5555_5555);
        push_req(lkvc_pkg::OP_GET, 32'h8000_0000, 31'h0);
        push_req(lkvc_pkg::OP_GET, 32'h7fff_ffff, 31'h0);
        push_req(lkvc_pkg::OP_GET, 32'hffff_ffff, 31'h0);
        push_req(lkvc_pkg::OP_GET, 32'h0000_0000, 31'h0);
        push_req(lkvc_pkg::OP_GET, 32'h0000_0001, 31'h0);
        push_req(lkvc_pkg::OP_PUT, 32'hffff_ffff, 31'h2aaa_aaaa);
        push_req(lkvc_pkg::OP_GET, 32'hffff_ffff, 31'h0);
        wait_quiet();

        // capacity lowered below the fill level
        write_capacity(5'd2);
        push_req(lkvc_pkg::OP_PUT, 32'h0000_0005, 31'h0000_0123);
        push_req(lkvc_pkg::OP_GET, 32'h8000_0000, 31'h0);
        push_req(lkvc_pkg::OP_GET, 32'h0000_0005, 31'h0);
        push_req(lkvc_pkg::OP_GET, 32'h7fff_ffff, 31'h0);
        wait_quiet();

        // capacity zero behaves as one
        write_capacity(5'd0);
        push_req(lkvc_pkg::OP_PUT, 32'h0000_0006, 31'h7fff_ffff);
        push_req(lkvc_pkg::OP_GET, 32'h0000_0006, 31'h0);
        push_req(lkvc_pkg::OP_GET, 32'h0000_0005, 31'h0);
        wait_quiet();

        // capacity above the depth saturates
        write_capacity(5'd31);
        push_req(lkvc_pkg::OP_PUT, 32'h0000_0007, 31'h0000_0001);
        push_req(lkvc_pkg::OP_GET, 32'h0000_0007, 31'h0);
        push_req(lkvc_pkg::OP_GET, 32'h0000_0006, 31'h0);
        wait_quiet();

        for (int p = 0; p < N_PHASES; p++) begin
            write_capacity(caps[p]);
            if (p == N_PHASES - 1) gaps_on = 1'b0;
            @(posedge i_clk);
            fill_phase(PHASE_REQS);
            wait_quiet();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
